// File: rtl/asms_pkg.sv
`default_nettype none

package asms_pkg;

	localparam int CMD_W     = 3;
	localparam int MAG_W     = 16;
	localparam int EVT_W     = 4;
	localparam int CYC_W     = 16;
	localparam int POS_W     = 24;
	localparam int LIMIT_W   = 20;
	localparam int THRESH_W  = 19;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 1;
	localparam int MAG_SHIFT = 3;

	localparam logic [LIMIT_W-1:0]  CONTRACT_LIMIT_RST  = LIMIT_W'(3500);
	localparam logic [THRESH_W-1:0] MAGNET_THRESH_RST   = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONTRACT_LIMIT   = 1'b0,
		CFG_MAGNET_THRESHOLD = 1'b1
	} cfg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_START    = 3'd0,
		CMD_CONTRACT = 3'd1,
		CMD_RELEASE  = 3'd2,
		CMD_END      = 3'd3,
		CMD_ENCODER  = 3'd4,
		CMD_STOP     = 3'd5
	} cmd_t;

	typedef enum logic [EVT_W-1:0] {
		EV_STARTED        = 4'd0,
		EV_START_IGNORED  = 4'd1,
		EV_CONTRACT_BEGUN = 4'd2,
		EV_CONTRACT_IGN   = 4'd3,
		EV_RELEASE_BEGUN  = 4'd4,
		EV_RELEASE_IGN    = 4'd5,
		EV_ENDED          = 4'd6,
		EV_END_IGNORED    = 4'd7,
		EV_DONE_MAGNET    = 4'd8,
		EV_DONE_ENCODER   = 4'd9,
		EV_RELEASE_DONE   = 4'd10
	} evt_t;

	typedef enum logic [3:0] {
		PH_RELEASED    = 4'b0001,
		PH_CONTRACTING = 4'b0010,
		PH_CONTRACTED  = 4'b0100,
		PH_RELEASING   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic   session_on;
		phase_t phase;
		logic   running;
		logic   direction_up;
	} seq_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  contract_limit;
		logic [THRESH_W-1:0] magnet_threshold;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/asms_if.sv
`default_nettype none

interface asms_cmd_if import asms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [MAG_W-1:0] magnet_x;

	modport source (output valid, output command, output magnet_x, input ready);
	modport sink (input valid, input command, input magnet_x, output ready);
endinterface

interface asms_evt_if import asms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EVT_W-1:0] event_code;
	logic [CYC_W-1:0] cycle_number;
	logic             motor_drive;
	logic             motor_dir;
	logic [POS_W-1:0] position;

	modport source (output valid, output event_code, output cycle_number,
		output motor_drive, output motor_dir, output position, input ready);
	modport sink (input valid, input event_code, input cycle_number,
		input motor_drive, input motor_dir, input position, output ready);
endinterface

`default_nettype wire

// File: rtl/asms_cfg_regs.sv
`default_nettype none

module asms_cfg_regs import asms_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 we,
	input  wire logic [CFG_IDX_W-1:0] index,
	input  wire logic [CFG_W-1:0]     wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.contract_limit   <= CONTRACT_LIMIT_RST;
			cfg_q.magnet_threshold <= MAGNET_THRESH_RST;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_CONTRACT_LIMIT: begin
					cfg_q.contract_limit <= wdata[LIMIT_W-1:0];
				end
				CFG_MAGNET_THRESHOLD: begin
					cfg_q.magnet_threshold <= wdata[THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/asms_step.sv
`default_nettype none

module asms_step import asms_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  wire seq_state_t         st,
	input  wire logic [COUNT_BITS-1:0] tick,
	input  wire logic [CYC_W-1:0]   cyc,
	input  wire cfg_t               cfg,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [MAG_W-1:0]   magnet_x,
	output seq_state_t              st_nx,
	output logic [COUNT_BITS-1:0]   tick_nx,
	output logic [CYC_W-1:0]        cyc_nx,
	output logic                    emit,
	output evt_t                    ev
);

	localparam int CMP_W = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;

	logic signed [CMP_W-1:0]    cnt_x;
	logic signed [CMP_W-1:0]    lim_x;
	logic signed [THRESH_W-1:0] scaled;
	logic                       mag_hit;
	logic                       enc_hit;
	logic                       pos_above;
	logic                       idle_rel;

	assign cnt_x     = CMP_W'($signed(tick));
	assign lim_x     = CMP_W'($signed({1'b0, cfg.contract_limit}));
	assign scaled    = {magnet_x, {MAG_SHIFT{1'b0}}};
	assign mag_hit   = scaled <= $signed(cfg.magnet_threshold);
	assign enc_hit   = cnt_x >= lim_x;
	assign pos_above = !tick[COUNT_BITS-1] && (tick != '0);
	assign idle_rel  = !st.running && (st.phase == PH_RELEASED);

	always_comb begin
		st_nx   = st;
		tick_nx = tick;
		cyc_nx  = cyc;
		emit    = 1'b0;
		ev      = EV_STARTED;
		case (cmd_t'(command))
			CMD_START: begin
				if (!st.session_on) begin
					emit = 1'b1;
					if (!idle_rel) begin
						ev = EV_START_IGNORED;
					end else begin
						st_nx.session_on = 1'b1;
						cyc_nx  = '0;
						tick_nx = '0;
						ev      = EV_STARTED;
					end
				end
			end
			CMD_CONTRACT: begin
				if (st.session_on) begin
					emit = 1'b1;
					if (!idle_rel) begin
						ev = EV_CONTRACT_IGN;
					end else begin
						cyc_nx             = cyc + CYC_W'(1);
						st_nx.direction_up = 1'b1;
						st_nx.running      = 1'b1;
						st_nx.phase        = PH_CONTRACTING;
						ev                 = EV_CONTRACT_BEGUN;
					end
				end
			end
			CMD_RELEASE: begin
				if (st.session_on) begin
					emit = 1'b1;
					if (st.running || (st.phase != PH_CONTRACTED)) begin
						ev = EV_RELEASE_IGN;
					end else begin
						st_nx.direction_up = 1'b0;
						st_nx.running      = 1'b1;
						st_nx.phase        = PH_RELEASING;
						ev                 = EV_RELEASE_BEGUN;
					end
				end
			end
			CMD_END: begin
				if (st.session_on) begin
					emit = 1'b1;
					if (!idle_rel) begin
						ev = EV_END_IGNORED;
					end else begin
						st_nx.session_on = 1'b0;
						ev               = EV_ENDED;
					end
				end
			end
			CMD_ENCODER: begin
				if (st.direction_up) begin
					tick_nx = tick + COUNT_BITS'(1);
				end else begin
					tick_nx = tick - COUNT_BITS'(1);
				end
			end
			CMD_STOP: begin
				if (st.running && (st.phase == PH_CONTRACTING)) begin
					if (mag_hit || enc_hit) begin
						emit          = 1'b1;
						st_nx.running = 1'b0;
						st_nx.phase   = PH_CONTRACTED;
						ev            = mag_hit ? EV_DONE_MAGNET : EV_DONE_ENCODER;
					end
				end else if (st.running && (st.phase == PH_RELEASING)) begin
					if (!pos_above) begin
						emit          = 1'b1;
						st_nx.running = 1'b0;
						st_nx.phase   = PH_RELEASED;
						tick_nx       = '0;
						ev            = EV_RELEASE_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/actuator_session_motion_sequencer.sv
`default_nettype none

// Contract/release actuator sequencer. Command words enter through an input
// register and are stepped from there against the session and motion state;
// a step that reports an event loads the result register. One word is taken
// every cycle unless a reporting word is held, and a result word passes the
// input register and then the result register before it is presented.
// While a result waits at the output, words that report nothing (encoder
// edges, stop checks that do not fire, commands in the wrong session state)
// keep flowing; a word that reports an event holds in the input register
// until the result register is free.
module actuator_session_motion_sequencer import asms_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	asms_cmd_if.sink                  cmd,
	asms_evt_if.source                evt
);

	cfg_t                  cfg;
	seq_state_t            st_q;
	seq_state_t            st_nx;
	logic [COUNT_BITS-1:0] tick_q;
	logic [COUNT_BITS-1:0] tick_nx;
	logic [CYC_W-1:0]      cyc_q;
	logic [CYC_W-1:0]      cyc_nx;
	logic                  emit;
	evt_t                  ev;
	logic [POS_W-1:0]      pos_nx;

	logic                  valid_s1;
	logic [CMD_W-1:0]      command_s1;
	logic [MAG_W-1:0]      magnet_x_s1;
	logic                  go_s1;

	logic                  valid_s2;
	logic [EVT_W-1:0]      event_code_s2;
	logic [CYC_W-1:0]      cycle_number_s2;
	logic                  motor_drive_s2;
	logic                  motor_dir_s2;
	logic [POS_W-1:0]      position_s2;

	asms_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	asms_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.st       (st_q),
		.tick     (tick_q),
		.cyc      (cyc_q),
		.cfg      (cfg),
		.command  (command_s1),
		.magnet_x (magnet_x_s1),
		.st_nx    (st_nx),
		.tick_nx  (tick_nx),
		.cyc_nx   (cyc_nx),
		.emit     (emit),
		.ev       (ev)
	);

	generate
		if (COUNT_BITS >= POS_W) begin : g_pos_trunc
			assign pos_nx = tick_nx[POS_W-1:0];
		end else begin : g_pos_sext
			assign pos_nx = {{(POS_W-COUNT_BITS){tick_nx[COUNT_BITS-1]}}, tick_nx};
		end
	endgenerate

	assign go_s1     = valid_s1 && (!emit || !valid_s2 || evt.ready);
	assign cmd.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1  <= cmd.command;
			magnet_x_s1 <= cmd.magnet_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.session_on   <= 1'b0;
			st_q.phase        <= PH_RELEASED;
			st_q.running      <= 1'b0;
			st_q.direction_up <= 1'b1;
			tick_q            <= '0;
			cyc_q             <= '0;
		end else if (go_s1) begin
			st_q   <= st_nx;
			tick_q <= tick_nx;
			cyc_q  <= cyc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && emit) begin
			valid_s2 <= 1'b1;
		end else if (evt.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			event_code_s2   <= ev;
			cycle_number_s2 <= cyc_nx;
			motor_drive_s2  <= st_nx.running;
			motor_dir_s2    <= st_nx.direction_up;
			position_s2     <= pos_nx;
		end
	end

	assign evt.valid        = valid_s2;
	assign evt.event_code   = event_code_s2;
	assign evt.cycle_number = cycle_number_s2;
	assign evt.motor_drive  = motor_drive_s2;
	assign evt.motor_dir    = motor_dir_s2;
	assign evt.position     = position_s2;

	a_run_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.running |-> (st_q.phase == PH_CONTRACTING || st_q.phase == PH_RELEASING))
		else $error("motor running outside a motion phase");

	a_no_session_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.session_on |-> (!st_q.running && st_q.phase == PH_RELEASED))
		else $error("motion state active without a session");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && emit && ev == EV_STARTED) |=>
		(evt.valid && evt.position == '0 && evt.cycle_number == '0))
		else $error("session start result not cleared");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && emit && valid_s2 && !evt.ready))
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import asms_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 6;

	typedef struct {
		logic [CMD_W-1:0] command;
		logic [MAG_W-1:0] magnet;
	} cmd_word_t;

	typedef struct {
		evt_t             code;
		logic [CYC_W-1:0] cycle;
		logic             drive;
		logic             dir;
		logic [POS_W-1:0] pos;
	} event_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	asms_cmd_if cmd_if ();
	asms_evt_if evt_if ();

	actuator_session_motion_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.evt       (evt_if)
	);

	cmd_word_t   command_backlog[$];
	event_word_t pending_events[$];
	cmd_word_t   next_word;
	logic        cmd_taken = 1'b0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          queued_items = 0;
	int          mismatches = 0;
	int          stall_cycles = 0;

	logic [LIMIT_W-1:0]  cfg_limit = CONTRACT_LIMIT_RST;
	logic [THRESH_W-1:0] cfg_thresh = MAGNET_THRESH_RST;

	logic             seq_session = 1'b0;
	phase_t           seq_phase = PH_RELEASED;
	logic             seq_running = 1'b0;
	logic             seq_dir_up = 1'b1;
	logic [POS_W-1:0] seq_ticks = '0;
	logic [CYC_W-1:0] seq_cycles = '0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic void advance_sequencer(input logic [CMD_W-1:0] c,
			input logic [MAG_W-1:0] mx, output bit fires, output event_word_t w);
		int   cnt;
		int   scaled;
		bit   idle_rel;
		bit   mag_hit;
		bit   enc_hit;
		evt_t code;

		fires = 1'b0;
		code = EV_STARTED;
		idle_rel = !seq_running && seq_phase == PH_RELEASED;
		cnt = int'($signed(seq_ticks));
		case (c)
			CMD_START: if (!seq_session) begin
				fires = 1'b1;
				if (!idle_rel) begin
					code = EV_START_IGNORED;
				end else begin
					seq_session = 1'b1;
					seq_cycles = '0;
					seq_ticks = '0;
					code = EV_STARTED;
				end
			end
			CMD_CONTRACT: if (seq_session) begin
				fires = 1'b1;
				if (!idle_rel) begin
					code = EV_CONTRACT_IGN;
				end else begin
					seq_cycles = seq_cycles + 1'b1;
					seq_dir_up = 1'b1;
					seq_running = 1'b1;
					seq_phase = PH_CONTRACTING;
					code = EV_CONTRACT_BEGUN;
				end
			end
			CMD_RELEASE: if (seq_session) begin
				fires = 1'b1;
				if (seq_running || seq_phase != PH_CONTRACTED) begin
					code = EV_RELEASE_IGN;
				end else begin
					seq_dir_up = 1'b0;
					seq_running = 1'b1;
					seq_phase = PH_RELEASING;
					code = EV_RELEASE_BEGUN;
				end
			end
			CMD_END: if (seq_session) begin
				fires = 1'b1;
				if (!idle_rel) begin
					code = EV_END_IGNORED;
				end else begin
					seq_session = 1'b0;
					code = EV_ENDED;
				end
			end
			CMD_ENCODER: begin
				seq_ticks = seq_dir_up ? seq_ticks + 1'b1 : seq_ticks - 1'b1;
			end
			CMD_STOP: if (seq_running) begin
				if (seq_phase == PH_CONTRACTING) begin
					scaled = int'($signed(mx)) * 8;
					mag_hit = scaled <= int'($signed(cfg_thresh));
					enc_hit = cnt >= int'(cfg_limit);
					if (mag_hit || enc_hit) begin
						fires = 1'b1;
						seq_running = 1'b0;
						seq_phase = PH_CONTRACTED;
						code = mag_hit ? EV_DONE_MAGNET : EV_DONE_ENCODER;
					end
				end else if (seq_phase == PH_RELEASING && cnt <= 0) begin
					fires = 1'b1;
					seq_running = 1'b0;
					seq_ticks = '0;
					seq_phase = PH_RELEASED;
					code = EV_RELEASE_DONE;
				end
			end
			default: ;
		endcase
		w.code = code;
		w.cycle = seq_cycles;
		w.drive = seq_running;
		w.dir = seq_dir_up;
		w.pos = seq_ticks;
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
		end else if (!cmd_if.valid || cmd_taken) begin
			if (command_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				next_word = command_backlog.pop_front();
				cmd_if.valid <= 1'b1;
				cmd_if.command <= next_word.command;
				cmd_if.magnet_x <= next_word.magnet;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
		evt_if.ready <= arst_n && $urandom_range(0, 99) >= rx_idle_pct;
	end

	always @(posedge clk) begin
		bit          fires;
		event_word_t w;
		event_word_t want;

		cmd_taken <= cmd_if.valid && cmd_if.ready;
		if (arst_n) begin
			if (evt_if.valid && evt_if.ready) begin
				if (pending_events.size() == 0) begin
					flag_mismatch("result word with none pending", evt_if.event_code, -1);
				end else begin
					want = pending_events.pop_front();
					if (evt_if.event_code !== want.code)
						flag_mismatch("event_code", evt_if.event_code, want.code);
					if (evt_if.cycle_number !== want.cycle)
						flag_mismatch("cycle_number", evt_if.cycle_number, want.cycle);
					if (evt_if.motor_drive !== want.drive)
						flag_mismatch("motor_drive", evt_if.motor_drive, want.drive);
					if (evt_if.motor_dir !== want.dir)
						flag_mismatch("motor_dir", evt_if.motor_dir, want.dir);
					if (evt_if.position !== want.pos)
						flag_mismatch("position", evt_if.position, want.pos);
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				advance_sequencer(cmd_if.command, cmd_if.magnet_x, fires, w);
				if (fires)
					pending_events.push_back(w);
			end
			if ((cmd_if.valid && cmd_if.ready) || (evt_if.valid && evt_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic queue_word(input logic [CMD_W-1:0] c, input logic [MAG_W-1:0] mx);
		cmd_word_t w;

		w.command = c;
		w.magnet = mx;
		command_backlog.push_back(w);
		if (c < CMD_SPARE_LO)
			queued_items++;
	endtask

	function automatic logic [MAG_W-1:0] magnet_stop();
		int hmax;

		hmax = int'($signed(cfg_thresh)) >>> 3;
		if (hmax > 32767)
			hmax = 32767;
		return MAG_W'(-32768 + int'($urandom_range(0, hmax + 32768)));
	endfunction

	function automatic logic [MAG_W-1:0] magnet_pass();
		int hmax;

		hmax = int'($signed(cfg_thresh)) >>> 3;
		if (hmax >= 32767)
			return MAG_W'($urandom);
		return MAG_W'(hmax + 1 + int'($urandom_range(0, 32766 - hmax)));
	endfunction

	function automatic logic [CMD_W-1:0] session_cmd();
		case ($urandom_range(0, 3))
			0: return CMD_START;
			1: return CMD_CONTRACT;
			2: return CMD_RELEASE;
			default: return CMD_END;
		endcase
	endfunction

	task automatic contract_round();
		int span;
		int ups;
		int downs;

		span = cfg_limit < 40 ? int'(cfg_limit) + 4 : 30;
		ups = $urandom_range(0, span);
		downs = ups + $urandom_range(0, 3);
		queue_word(CMD_CONTRACT, $urandom);
		if ($urandom_range(0, 5) == 0)
			queue_word(session_cmd(), $urandom);
		repeat (ups) begin
			queue_word(CMD_ENCODER, $urandom);
			if ($urandom_range(0, 3) == 0)
				queue_word(CMD_STOP, magnet_pass());
		end
		queue_word(CMD_STOP, $urandom_range(0, 2) == 0 ? magnet_stop() : magnet_pass());
		queue_word(CMD_STOP, magnet_stop());
		if ($urandom_range(0, 5) == 0)
			queue_word(session_cmd(), $urandom);
		queue_word(CMD_RELEASE, $urandom);
		if ($urandom_range(0, 5) == 0)
			queue_word(CMD_RELEASE, $urandom);
		repeat (downs) begin
			queue_word(CMD_ENCODER, $urandom);
			if ($urandom_range(0, 3) == 0)
				queue_word(CMD_STOP, $urandom);
		end
		queue_word(CMD_STOP, $urandom);
	endtask

	task automatic session_script();
		queue_word(CMD_START, $urandom);
		repeat ($urandom_range(1, 4))
			contract_round();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4))
				queue_word(CMD_ENCODER, $urandom);
		if ($urandom_range(0, 5) != 0)
			queue_word(CMD_END, $urandom);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (command_backlog.size() != 0 || cmd_if.valid || pending_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int target);
		queued_items = 0;
		while (queued_items < target) begin
			if ($urandom_range(0, 99) < 85) begin
				session_script();
			end else begin
				repeat ($urandom_range(1, 5))
					queue_word($urandom_range(0, 7), $urandom);
			end
		end
		wait_idle();
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CONTRACT_LIMIT)
			cfg_limit = data[LIMIT_W-1:0];
		else
			cfg_thresh = data[THRESH_W-1:0];
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CONTRACT_LIMIT;
		cfg_wdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.command = CMD_START;
		cmd_if.magnet_x = '0;
		evt_if.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		tx_idle_pct = 29;
		rx_idle_pct = 78;
		queue_word(CMD_ENCODER, 16'h0000);
		queue_word(CMD_STOP, 16'h0000);
		queue_word(CMD_SPARE_LO, 16'h0000);
		queue_word(CMD_SPARE_HI, 16'hFFFF);
		queue_word(CMD_CONTRACT, 16'h0000);
		queue_word(CMD_RELEASE, 16'h0000);
		queue_word(CMD_END, 16'h0000);
		queue_word(CMD_START, 16'h0000);
		queue_word(CMD_START, 16'h0000);
		queue_word(CMD_RELEASE, 16'h0000);
		queue_word(CMD_CONTRACT, 16'h0000);
		queue_word(CMD_CONTRACT, 16'h0000);
		queue_word(CMD_START, 16'h0000);
		queue_word(CMD_END, 16'h0000);
		repeat (3) queue_word(CMD_ENCODER, 16'h0000);
		queue_word(CMD_STOP, 16'h7FFF);
		queue_word(CMD_STOP, 16'h8000);
		queue_word(CMD_RELEASE, 16'h0000);
		queue_word(CMD_RELEASE, 16'h0000);
		repeat (5) queue_word(CMD_ENCODER, 16'h0000);
		queue_word(CMD_STOP, 16'h0000);
		queue_word(CMD_ENCODER, 16'h0000);
		queue_word(CMD_END, 16'h0000);
		queue_word(CMD_START, 16'h0000);
		wait_idle();

		write_reg(CFG_CONTRACT_LIMIT, 20'd0);
		write_reg(CFG_MAGNET_THRESHOLD, 20'd0);
		run_phase(110);
		write_reg(CFG_CONTRACT_LIMIT, 20'hFFFFF);
		write_reg(CFG_MAGNET_THRESHOLD, 20'h40000);
		run_phase(110);

		tx_idle_pct = 78;
		rx_idle_pct = 29;
		write_reg(CFG_CONTRACT_LIMIT, 20'd12);
		write_reg(CFG_MAGNET_THRESHOLD, 20'h3FFFF);
		run_phase(110);
		write_reg(CFG_CONTRACT_LIMIT, CFG_W'($urandom_range(0, 30)));
		write_reg(CFG_MAGNET_THRESHOLD, CFG_W'($urandom));
		run_phase(110);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(CFG_CONTRACT_LIMIT, 20'd3500);
		write_reg(CFG_MAGNET_THRESHOLD, CFG_W'($urandom));
		run_phase(110);
		write_reg(CFG_CONTRACT_LIMIT, 20'd7);
		write_reg(CFG_MAGNET_THRESHOLD, 20'hC0000);
		run_phase(110);

		if (pending_events.size() != 0)
			flag_mismatch("results never delivered", 0, pending_events.size());
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
